>>> hdl/tkls_pkg.sv
// ----------------------------------------------------------------------------
// tkls_pkg
// Shared types and constants for the streaming top-k logit selector.
// ----------------------------------------------------------------------------
package tkls_pkg;

  localparam int KEEP_W = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd8;
  localparam int VALUE_W = 32;
  localparam int RANK_W = 4;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EMIT,
    ST_CLEAR
  } tkls_state_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;   // rank the accepted word into the list
    logic advance;  // emit pointer steps to next entry
    logic clear;    // empty list, reset counters
  } tkls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_any;   // at least one entry to emit
    logic emit_last;  // emit pointer sits on last entry
  } tkls_stat_t;

  // Monotone unsigned key; -0 folded onto +0.
  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] v;
    v = (b[VALUE_W-2:0] == '0) ? '0 : b;
    order_key = v[VALUE_W-1] ? ~v : (v | {1'b1, {(VALUE_W-1){1'b0}}});
  endfunction

  function automatic logic is_nan(input logic [VALUE_W-1:0] b);
    is_nan = (b[VALUE_W-2:0] > 31'h7F80_0000);
  endfunction

endpackage

>>> hdl/tkls_datapath.sv
// ----------------------------------------------------------------------------
// tkls_datapath
// Sorted best-k register list with parallel compare-and-shift insert, plus
// index counter and emit pointer.
// ----------------------------------------------------------------------------
module tkls_datapath #(
  parameter int MAX_KEEP   = 16,
  parameter int INDEX_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tkls_pkg::tkls_cmd_t           cmd,
  output tkls_pkg::tkls_stat_t          stat,
  input  logic [tkls_pkg::KEEP_W-1:0]   keep_count,
  input  logic [31:0]                   logit_bits,
  output logic [INDEX_BITS-1:0]         token_index,
  output logic [31:0]                   value_bits,
  output logic [tkls_pkg::RANK_W-1:0]   rank
);
  import tkls_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int PW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  logic [INDEX_BITS-1:0] best_index [MAX_KEEP];
  logic [VALUE_W-1:0]    best_value [MAX_KEEP];
  logic [CW-1:0]         filled_count;
  logic [INDEX_BITS-1:0] position_counter;
  logic [CW-1:0]         emit_ptr;

  logic [CW-1:0] k_eff, n_cur;
  logic [VALUE_W-1:0] key;
  logic [MAX_KEEP-1:0] ge;     // kept entry ranks ahead of new word
  logic [CW-1:0] p;
  logic do_ins;

  always_comb begin
    if (keep_count == '0) k_eff = CW'(1);
    else if (32'(keep_count) > MAX_KEEP) k_eff = CW'(MAX_KEEP);
    else k_eff = CW'(keep_count);
    n_cur = (filled_count < k_eff) ? filled_count : k_eff;
    key = order_key(logit_bits);
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = (CW'(i) < n_cur) && (order_key(best_value[i]) >= key);
    end
    // list is sorted, so ge is a prefix of ones
    p = CW'($countones(ge));
    do_ins = cmd.insert && !is_nan(logit_bits) && (p < k_eff);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (do_ins && CW'(i) >= p && CW'(i) < k_eff) begin
        if (CW'(i) == p) begin
          best_index[i] <= position_counter;
          best_value[i] <= logit_bits;
        end else begin
          best_index[i] <= best_index[(i > 0) ? i-1 : 0];
          best_value[i] <= best_value[(i > 0) ? i-1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      filled_count <= '0;
      position_counter <= '0;
      emit_ptr <= '0;
    end else begin
      if (cmd.insert) begin
        position_counter <= position_counter + 1'b1;
        if (!is_nan(logit_bits)) begin
          if (do_ins) filled_count <= (n_cur < k_eff) ? n_cur + 1'b1 : k_eff;
          else filled_count <= n_cur;
        end
      end
      if (cmd.advance) emit_ptr <= emit_ptr + 1'b1;
    end
  end

  logic [CW-1:0] n_emit;
  assign n_emit = (filled_count < k_eff) ? filled_count : k_eff;
  assign stat.emit_any  = (n_emit != '0);
  assign stat.emit_last = (emit_ptr + 1'b1 == n_emit);

  assign token_index = best_index[emit_ptr[PW-1:0]];
  assign value_bits  = best_value[emit_ptr[PW-1:0]];
  assign rank        = RANK_W'(emit_ptr);

endmodule

>>> hdl/tkls_ctrl.sv
// ----------------------------------------------------------------------------
// tkls_ctrl
// Collect / emit / clear sequencer and output handshake.
// ----------------------------------------------------------------------------
module tkls_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 vector_end,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 run_end,
  output tkls_pkg::tkls_cmd_t  cmd,
  input  tkls_pkg::tkls_stat_t stat
);
  import tkls_pkg::*;

  tkls_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_COLLECT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (in_valid && vector_end) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!stat.emit_any) state_next = ST_CLEAR;
        else if (out_ready && stat.emit_last) state_next = ST_CLEAR;
      end
      ST_CLEAR: state_next = ST_COLLECT;
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        cmd.insert = in_valid;
      end
      ST_EMIT: begin
        out_valid = stat.emit_any;
        cmd.advance = stat.emit_any && out_ready;
      end
      ST_CLEAR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

  assign run_end = stat.emit_last;

endmodule

>>> hdl/top_k_logit_selector_core.sv
// ----------------------------------------------------------------------------
// top_k_logit_selector_core
// Streaming top-k selection over float32 logits, emitted in rank order.
// ----------------------------------------------------------------------------
// channel | signals                                  | direction
// in      | in_valid/in_ready, logit_bits, vector_end | sink
// out     | out_valid/out_ready, token_index,        | source
//         | value_bits, rank, run_end                |
// cfg     | APB psel..prdata, keep_count at 0x0      | slave
//
// One word per cycle while collecting (parallel compare-and-shift insert).
// After vector_end: one result word per cycle while out_ready, then one
// clear cycle; input is held off over emit and clear.
// Reset: synchronous rst; list empty, keep_count = 8.
module top_k_logit_selector_core #(
  parameter int MAX_KEEP   = 16,
  parameter int INDEX_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           logit_bits,
  input  logic                  vector_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS-1:0] token_index,
  output logic [31:0]           value_bits,
  output logic [3:0]            rank,
  output logic                  run_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tkls_pkg::*;

  logic [KEEP_W-1:0] keep_count;
  tkls_cmd_t  cmd;
  tkls_stat_t stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) keep_count <= KEEP_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) keep_count <= pwdata[KEEP_W-1:0];
  end
  assign prdata = (paddr == 2'd0) ? {{(32-KEEP_W){1'b0}}, keep_count} : '0;

  tkls_ctrl u_ctrl (
    .clk, .rst, .in_valid, .vector_end, .in_ready, .out_valid, .out_ready,
    .run_end, .cmd, .stat
  );

  tkls_datapath #(.MAX_KEEP(MAX_KEEP), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .keep_count, .logit_bits, .token_index,
    .value_bits, .rank
  );

endmodule

>>> hdl/tkls_checker.sv
// ----------------------------------------------------------------------------
// tkls_checker
// Port-level checks on the top-k selector.
// ----------------------------------------------------------------------------
module tkls_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        vector_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  rank,
  input logic        run_end,
  input logic        pready
);
  // no input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready during emit");

  // a vector end stops intake next cycle
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && vector_end |=> !in_ready) else $error("intake after end");

  // after a non-final word is taken, next word has rank+1
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_end |=> out_valid && rank == $past(rank) + 4'd1)
    else $error("rank sequence broken");

  // the final word ends the burst
  a_end_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && run_end |=> !out_valid) else $error("word after run_end");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind top_k_logit_selector_core tkls_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .vector_end, .out_valid, .out_ready,
  .rank, .run_end, .pready
);
